>>> rtl/bmhpq_pkg.sv
// Shared types and codes for the min-priority queue.
`timescale 1ns / 1ps
package bmhpq_pkg;

	localparam int VAL_W   = 32;
	localparam int COUNT_W = 7;

	localparam logic OP_ENQ = 1'b0;
	localparam logic OP_DEQ = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic                    opcode;
		logic signed [VAL_W-1:0] value;
	} bmhpq_req_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] result_value;
		logic [1:0]              status;
		logic [COUNT_W-1:0]      entry_count;
	} bmhpq_rsp_t;

	// Row-wide command broadcast to every cell.
	typedef struct packed {
		logic enq;
		logic deq;
	} bmhpq_ctl_t;

endpackage

>>> rtl/bmhpq_cell.sv
// One storage cell of the sorted row: holds one entry, shifts on command.
`timescale 1ns / 1ps
module bmhpq_cell (
	input  logic                                  clk,
	input  bmhpq_pkg::bmhpq_ctl_t                 ctl,
	input  logic                                  occupied,
	input  logic signed [bmhpq_pkg::VAL_W-1:0]    new_val,
	input  logic signed [bmhpq_pkg::VAL_W-1:0]    left_val,
	input  logic                                  left_keep,
	input  logic signed [bmhpq_pkg::VAL_W-1:0]    right_val,
	output logic signed [bmhpq_pkg::VAL_W-1:0]    val,
	output logic                                  keep
);
	import bmhpq_pkg::*;

	logic signed [VAL_W-1:0] val_q;

	// Stay in place when occupied and not larger than the incoming value.
	assign keep = occupied && !(new_val < val_q);
	assign val  = val_q;

	always_ff @(posedge clk) begin
		if (ctl.enq && !keep) begin
			// insertion point takes the new value, cells behind it move right
			val_q <= left_keep ? new_val : left_val;
		end else if (ctl.deq) begin
			val_q <= right_val;
		end
	end

endmodule

>>> rtl/binary_min_heap_priority_queue.sv
// Top level of the min-priority queue: cell row, count and response register.
// The response is registered: it appears in the cycle after the request transfer.
// Throughput: one request per cycle unless stalled; all cells update in
//   parallel, so the compare of the new value with each cell sets the cycle.
// Reset (arst_n low) clears the entry count and the response valid at once;
//   cell contents are not cleared and are read only below the count.
`timescale 1ns / 1ps
module binary_min_heap_priority_queue #(
	parameter int CAPACITY = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  bmhpq_pkg::bmhpq_req_t req,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output bmhpq_pkg::bmhpq_rsp_t rsp
);
	import bmhpq_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int EXT_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

	logic [CNT_W-1:0]        count_q;
	logic [CNT_W-1:0]        count_nxt;
	logic [EXT_W-1:0]        count_ext;
	logic                    rsp_valid_q;
	bmhpq_rsp_t              rsp_q;
	logic                    accept;
	logic                    is_full;
	logic                    is_empty;
	bmhpq_ctl_t              ctl;
	logic [1:0]              status_nxt;
	logic signed [VAL_W-1:0] val_w [CAPACITY];
	logic                    keep_w [CAPACITY];

	// Accept a new request when the response register is free or draining.
	assign req_stall = rsp_valid_q && rsp_stall;
	assign accept    = req_valid && !req_stall;

	assign is_full  = (count_q == CNT_W'(CAPACITY));
	assign is_empty = (count_q == '0);

	// Drop an enqueue into a full row and a dequeue from an empty one.
	always_comb begin
		ctl.enq = accept && (req.opcode == OP_ENQ) && !is_full;
		ctl.deq = accept && (req.opcode == OP_DEQ) && !is_empty;
	end

	always_comb begin
		unique case (req.opcode)
			OP_ENQ:  status_nxt = is_full ? ST_FULL : ST_OK;
			OP_DEQ:  status_nxt = is_empty ? ST_EMPTY : ST_OK;
			default: status_nxt = ST_OK;
		endcase
	end

	always_comb begin
		count_nxt = count_q;
		if (ctl.enq) begin
			count_nxt = count_q + CNT_W'(1);
		end else if (ctl.deq) begin
			count_nxt = count_q - CNT_W'(1);
		end
	end

	// Sorted row of cells: cell 0 holds the smallest entry. On enqueue every
	// cell compares against the new value in parallel and the tail shifts
	// right by one; on dequeue the whole row shifts left by one.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [VAL_W-1:0] left_val;
		logic                    left_keep;
		logic signed [VAL_W-1:0] right_val;
		logic                    occupied;

		assign occupied = (count_q > CNT_W'(i));

		if (i == 0) begin : g_head
			assign left_val  = req.value;
			assign left_keep = 1'b0;
		end else begin : g_body
			assign left_val  = val_w[i-1];
			assign left_keep = keep_w[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_val = val_w[i];
		end else begin : g_mid
			assign right_val = val_w[i+1];
		end

		bmhpq_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.occupied  (occupied),
			.new_val   (req.value),
			.left_val  (left_val),
			.left_keep (left_keep),
			.right_val (right_val),
			.val       (val_w[i]),
			.keep      (keep_w[i])
		);
	end

	assign count_ext = EXT_W'(count_nxt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_nxt;
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Load the response payload on every request transfer.
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q.result_value <= ctl.deq ? val_w[0] : '0;
			rsp_q.status       <= status_nxt;
			rsp_q.entry_count  <= count_ext[COUNT_W-1:0];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> rsp_valid_q)
		else $error("request transfer without response");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.opcode == OP_ENQ && is_full) |=> $stable(count_q))
		else $error("enqueue into full row changed count");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.status != ST_OK) |-> (rsp_q.result_value == '0))
		else $error("failed request returned nonzero value");

	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= CNT_W'(2)) |-> !(val_w[1] < val_w[0]))
		else $error("head cell not smallest");

endmodule
